>>> hdl/cpc_pkg.sv
// shared types and constants for the convex polygon clipper
// no dependencies; used by convex_polygon_clipper and the testbench

package cpc_pkg;

  // default sizing
  localparam int MAX_SUBJECT_VERTS_DEF = 32;
  localparam int MAX_CLIP_VERTS_DEF    = 6;
  localparam int COORD_BITS_DEF        = 16;

  // fixed port geometry
  localparam int FIELD_W    = 16;   // width of one coordinate field on the ports
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CLIP_REGS  = 6;    // clip vertex registers in the register map

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_ENABLED  = 3'd0,
    REG_CLIP_COUNT    = 3'd1,
    REG_CLIP_VERTEX_0 = 3'd2,
    REG_CLIP_VERTEX_1 = 3'd3,
    REG_CLIP_VERTEX_2 = 3'd4,
    REG_CLIP_VERTEX_3 = 3'd5,
    REG_CLIP_VERTEX_4 = 3'd6,
    REG_CLIP_VERTEX_5 = 3'd7
  } reg_idx_t;

  // sign of a cross product, both bits low for zero
  typedef struct packed {
    logic neg;
    logic pos;
  } sign_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CV_RD,
    ST_CV_MUL,
    ST_CV_SUB,
    ST_CV_EVAL,
    ST_EDGE_Q1,
    ST_EDGE_Q2,
    ST_PASS_RD,
    ST_PASS_VIS,
    ST_PASS_WAIT,
    ST_PASS_DEC,
    ST_PASS_PUSH,
    ST_PASS_END,
    ST_PASS_FIN,
    ST_MEET_NUM,
    ST_MEET_DEN,
    ST_MEET_GETN,
    ST_MEET_GETD,
    ST_MEET_MUL,
    ST_MEET_SUM,
    ST_MEET_GO,
    ST_MEET_DIV,
    ST_MEET_PUSH,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_EMPTY
  } state_t;

  function automatic logic sign_opp(input sign_t a, input sign_t b);
    return (a.pos && b.neg) || (a.neg && b.pos);
  endfunction

endpackage

>>> hdl/cpc_mem.sv
// ping-pong vertex store: two synchronous banks, one write and one read per cycle
// depends on nothing; instantiated by convex_polygon_clipper

module cpc_mem #(
  parameter int DEPTH = 38,
  parameter int DW    = 32,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          wr_bank,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_bank,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] bank0 [DEPTH];
  logic [DW-1:0] bank1 [DEPTH];
  logic [DW-1:0] rd0;
  logic [DW-1:0] rd1;
  logic          rd_bank_q;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      bank0[wr_addr] <= wr_data;
    end
    rd0 <= bank0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_bank) begin
      bank1[wr_addr] <= wr_data;
    end
    rd1 <= bank1[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_bank_q <= rd_bank;
  end

  assign rd_data = rd_bank_q ? rd1 : rd0;

endmodule

>>> hdl/cpc_cross.sv
// two-stage 2-d cross product ax*by - ay*bx
// depends on nothing; instantiated by convex_polygon_clipper

module cpc_cross #(
  parameter int XW = 17
) (
  input  logic                 clk,
  input  logic signed [XW-1:0] ax,
  input  logic signed [XW-1:0] ay,
  input  logic signed [XW-1:0] bx,
  input  logic signed [XW-1:0] by,
  output logic signed [2*XW:0] res
);

  logic signed [2*XW-1:0] p1;
  logic signed [2*XW-1:0] p2;

  always_ff @(posedge clk) begin
    p1  <= ax * by;
    p2  <= ay * bx;
    res <= {p1[2*XW-1], p1} - {p2[2*XW-1], p2};
  end

endmodule

>>> hdl/cpc_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on nothing; the caller guarantees |quotient| fits in QW bits

module cpc_div #(
  parameter int NW = 53,
  parameter int DW = 35,
  parameter int QW = 17,
  parameter int OW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] numer,
  input  logic signed [DW-1:0] denom,
  output logic                 done,
  output logic signed [OW-1:0] quot
);

  localparam int RMW = NW - QW;
  localparam int CNW = $clog2(QW + 1);

  logic [RMW-1:0] rem;
  logic [QW-1:0]  qr;
  logic [DW-1:0]  dmag;
  logic           neg;
  logic           busy;
  logic [CNW-1:0] cnt;

  logic [NW-1:0]  nmag;
  logic [RMW-1:0] sh;
  logic           ge;
  logic [QW-1:0]  qfin;
  logic [QW-1:0]  qs;

  always_comb begin
    nmag = numer[NW-1] ? NW'(-numer) : NW'(numer);
    sh   = {rem[RMW-2:0], qr[QW-1]};
    ge   = sh >= RMW'(dmag);
    qfin = {qr[QW-2:0], ge};
    qs   = neg ? QW'(-qfin) : qfin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse on the step that settles the last quotient bit
      done <= !start && busy && (cnt == CNW'(QW - 1));
      if (start) begin
        rem  <= nmag[NW-1:QW];
        qr   <= nmag[QW-1:0];
        dmag <= denom[DW-1] ? DW'(-denom) : DW'(denom);
        neg  <= numer[NW-1] ^ denom[DW-1];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? sh - RMW'(dmag) : sh;
        qr  <= qfin;
        cnt <= cnt + CNW'(1);
        if (cnt == CNW'(QW - 1)) begin
          busy <= 1'b0;
          quot <= qs[OW-1:0];
        end
      end
    end
  end

endmodule

>>> hdl/convex_polygon_clipper.sv
// convex polygon clipper: subject vertices load at one item per cycle while the block is idle,
// and the clip runs on the last item: a convexity check over the clip vertices, then per clip
//   edge one pass over the stored vertices, with an intersection (a division per coordinate
//   on the serial divider) at each crossing; results leave from the ping-pong vertex store
// the shared cross product unit and the serial divider set the pace; one polygon at a time
// reset (rst, synchronous, active high) clears config, state, counts and handshakes; no clearing pass
// depends on cpc_pkg, cpc_mem, cpc_cross, cpc_div

module convex_polygon_clipper #(
  parameter int MAX_SUBJECT_VERTS = cpc_pkg::MAX_SUBJECT_VERTS_DEF,
  parameter int MAX_CLIP_VERTS    = cpc_pkg::MAX_CLIP_VERTS_DEF,
  parameter int COORD_BITS        = cpc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // subject vertex items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*cpc_pkg::FIELD_W-1:0]       s_axis_tdata,  // vertex_x, vertex_y
  input  logic                                s_axis_tlast,  // final_vertex
  // clipped vertex items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [2*cpc_pkg::FIELD_W-1:0]       m_axis_tdata,  // out_x, out_y
  output logic                                m_axis_tlast,  // out_last
  output logic [1:0]                          m_axis_tuser,  // out_empty, input_overflow
  // register writes
  input  logic                                cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CB  = COORD_BITS;
  localparam int FW  = cpc_pkg::FIELD_W;
  localparam int XW  = CB + 1;                      // coordinate difference
  localparam int RW  = 2 * XW + 1;                  // cross product
  localparam int NW  = XW + RW + 1;                 // intersection numerator
  localparam int CAP = MAX_SUBJECT_VERTS + MAX_CLIP_VERTS;
  localparam int AW  = $clog2(CAP);
  localparam int LW  = $clog2(CAP + 1);
  localparam int CW  = $clog2(MAX_SUBJECT_VERTS + 1);
  localparam int PW  = 2 * CB;

  // configuration registers
  logic                          cfg_en;
  logic [2:0]                    cfg_cnt;
  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_vert [cpc_pkg::CLIP_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_en  <= 1'b0;
      cfg_cnt <= '0;
      for (int i = 0; i < cpc_pkg::CLIP_REGS; i++) begin
        cfg_vert[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cpc_pkg::reg_idx_t'(cfg_index))
        cpc_pkg::REG_CLIP_ENABLED:  cfg_en      <= cfg_data[0];
        cpc_pkg::REG_CLIP_COUNT:    cfg_cnt     <= cfg_data[2:0];
        cpc_pkg::REG_CLIP_VERTEX_0: cfg_vert[0] <= cfg_data;
        cpc_pkg::REG_CLIP_VERTEX_1: cfg_vert[1] <= cfg_data;
        cpc_pkg::REG_CLIP_VERTEX_2: cfg_vert[2] <= cfg_data;
        cpc_pkg::REG_CLIP_VERTEX_3: cfg_vert[3] <= cfg_data;
        cpc_pkg::REG_CLIP_VERTEX_4: cfg_vert[4] <= cfg_data;
        cpc_pkg::REG_CLIP_VERTEX_5: cfg_vert[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // clip vertex coordinates, low COORD_BITS of each half
  function automatic logic signed [CB-1:0] cfg_x(input logic [2:0] idx);
    return cfg_vert[idx][CB-1:0];
  endfunction

  function automatic logic signed [CB-1:0] cfg_y(input logic [2:0] idx);
    return cfg_vert[idx][FW+CB-1:FW];
  endfunction

  function automatic logic signed [XW-1:0] dif(input logic signed [CB-1:0] a,
                                              input logic signed [CB-1:0] b);
    return XW'(a) - XW'(b);
  endfunction

  // sequencer and datapath registers
  cpc_pkg::state_t state, state_next;

  logic          sel;          // bank holding the current polygon
  logic [CW-1:0] cnt;          // subject vertices stored
  logic          ovf_flag;     // a subject vertex was dropped so far
  logic          ovf_run;      // overflow reported with this polygon's results
  logic [2:0]    n;            // clip vertices in use
  logic [3:0]    k;            // clip vertices fetched by the convexity check
  logic [2:0]    cidx;
  cpc_pkg::sign_t sgn_s;       // common turn direction seen so far
  logic          ori_neg;      // clip polygon runs clockwise
  logic [2:0]    e;            // current clip edge
  logic [2:0]    e2;
  logic [LW-1:0] len;          // vertices in the current polygon
  logic [LW-1:0] j;            // vertex walk
  logic [LW-1:0] wlen;         // vertices written by this pass
  logic          ret_close;    // intersection closes the polygon
  logic          axis;         // 0 x, 1 y
  logic          m_valid;
  logic          m_load;       // output register takes a new item

  logic signed [CB-1:0] a0x, a0y, a1x, a1y, a2x, a2y;
  logic signed [CB-1:0] q1x, q1y;
  logic signed [XW-1:0] dqx, dqy;
  logic signed [CB-1:0] cx, cy, sx, sy, fx, fy;
  logic signed [CB-1:0] m1x, m1y, m2x, m2y;
  logic signed [CB-1:0] rx, ry;
  cpc_pkg::sign_t vc, vs, vf;
  logic signed [RW-1:0]    num, den;
  logic signed [CB+RW-1:0] prod_a;
  logic signed [XW+RW-1:0] prod_b;
  logic signed [NW-1:0]    numer;
  logic [FW-1:0] ox, oy;
  logic          olast, oempty, oovf;

  // memory port
  logic          mem_we;
  logic          wr_bank;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_data;
  logic [PW-1:0] rd_data;
  logic signed [CB-1:0] rd_x, rd_y;

  // shared cross product unit
  logic signed [XW-1:0] x_ax, x_ay, x_bx, x_by;
  logic signed [RW-1:0] x_res;

  // divider
  logic                 div_start;
  logic                 div_done;
  logic signed [CB-1:0] div_q;

  // decisions shared by both blocks
  logic                 in_acc;
  logic                 room_s;
  logic                 room_w;
  logic                 slot_free;
  logic [2:0]           n_in;
  logic signed [CB-1:0] in_x, in_y;
  cpc_pkg::sign_t       z;         // raw sign of the cross product unit
  cpc_pkg::sign_t       vis_now;   // sign seen from the clip edge's inside
  cpc_pkg::sign_t       s_new;
  logic                 cv_fail;
  logic signed [XW-1:0] dp_sel;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign room_s    = cnt < CW'(MAX_SUBJECT_VERTS);
  assign room_w    = wlen < LW'(CAP);
  assign slot_free = !m_valid || m_axis_tready;
  assign m_load    = slot_free &&
                     (state == cpc_pkg::ST_OUT_LD || state == cpc_pkg::ST_EMPTY);
  assign n_in      = (cfg_cnt > 3'(MAX_CLIP_VERTS)) ? 3'(MAX_CLIP_VERTS) : cfg_cnt;
  assign in_x      = s_axis_tdata[CB-1:0];
  assign in_y      = s_axis_tdata[FW+CB-1:FW];
  assign rd_x      = rd_data[CB-1:0];
  assign rd_y      = rd_data[PW-1:CB];

  always_comb begin
    z.neg       = x_res[RW-1];
    z.pos       = !x_res[RW-1] && (x_res != '0);
    vis_now     = ori_neg ? {z.pos, z.neg} : z;
    s_new       = (sgn_s == '0) ? z : sgn_s;
    cv_fail     = (z != '0) && (z != s_new);
    dp_sel      = axis ? dif(m2y, m1y) : dif(m2x, m1x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory port, cross unit operands, divider start
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    wr_bank    = ~sel;
    wr_addr    = wlen[AW-1:0];
    wr_data    = {cy, cx};
    x_ax       = '0;
    x_ay       = '0;
    x_bx       = '0;
    x_by       = '0;
    div_start  = 1'b0;
    unique case (state)
      cpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (room_s) begin
            mem_we  = 1'b1;
            wr_bank = sel;
            wr_addr = AW'(cnt);
            wr_data = {in_y, in_x};
          end
          if (s_axis_tlast) begin
            state_next = (n_in == '0 || !cfg_en) ? cpc_pkg::ST_EMPTY : cpc_pkg::ST_CV_RD;
          end
        end
      end
      cpc_pkg::ST_CV_RD: begin
        if (k >= 4'd2) begin
          state_next = cpc_pkg::ST_CV_MUL;
        end
      end
      cpc_pkg::ST_CV_MUL: begin
        x_ax       = dif(a1x, a0x);
        x_ay       = dif(a1y, a0y);
        x_bx       = dif(a2x, a1x);
        x_by       = dif(a2y, a1y);
        state_next = cpc_pkg::ST_CV_SUB;
      end
      cpc_pkg::ST_CV_SUB: state_next = cpc_pkg::ST_CV_EVAL;
      cpc_pkg::ST_CV_EVAL: begin
        priority if (cv_fail) begin
          state_next = cpc_pkg::ST_EMPTY;
        end else if (k == {1'b0, n} + 4'd2) begin
          state_next = (s_new == '0) ? cpc_pkg::ST_EMPTY : cpc_pkg::ST_EDGE_Q1;
        end else begin
          state_next = cpc_pkg::ST_CV_RD;
        end
      end
      cpc_pkg::ST_EDGE_Q1: state_next = cpc_pkg::ST_EDGE_Q2;
      cpc_pkg::ST_EDGE_Q2: state_next = cpc_pkg::ST_PASS_RD;
      cpc_pkg::ST_PASS_RD: state_next = cpc_pkg::ST_PASS_VIS;
      cpc_pkg::ST_PASS_VIS: begin
        x_ax       = dif(q1x, rd_x);
        x_ay       = dif(q1y, rd_y);
        x_bx       = dqx;
        x_by       = dqy;
        state_next = cpc_pkg::ST_PASS_WAIT;
      end
      cpc_pkg::ST_PASS_WAIT: state_next = cpc_pkg::ST_PASS_DEC;
      cpc_pkg::ST_PASS_DEC: begin
        state_next = (j != '0 && cpc_pkg::sign_opp(vs, vis_now)) ?
                     cpc_pkg::ST_MEET_NUM : cpc_pkg::ST_PASS_PUSH;
      end
      cpc_pkg::ST_PASS_PUSH: begin
        if (!vc.neg && room_w) begin
          mem_we = 1'b1;
        end
        state_next = (j + LW'(1) == len) ? cpc_pkg::ST_PASS_END : cpc_pkg::ST_PASS_RD;
      end
      cpc_pkg::ST_PASS_END: begin
        priority if (wlen == '0) begin
          state_next = cpc_pkg::ST_EMPTY;
        end else if (cpc_pkg::sign_opp(vs, vf)) begin
          state_next = cpc_pkg::ST_MEET_NUM;
        end else begin
          state_next = cpc_pkg::ST_PASS_FIN;
        end
      end
      cpc_pkg::ST_PASS_FIN: begin
        state_next = (e + 3'd1 == n) ? cpc_pkg::ST_OUT_RD : cpc_pkg::ST_EDGE_Q1;
      end
      cpc_pkg::ST_MEET_NUM: begin
        x_ax       = dif(q1x, m1x);
        x_ay       = dif(q1y, m1y);
        x_bx       = dqx;
        x_by       = dqy;
        state_next = cpc_pkg::ST_MEET_DEN;
      end
      cpc_pkg::ST_MEET_DEN: begin
        x_ax       = dif(m2x, m1x);
        x_ay       = dif(m2y, m1y);
        x_bx       = dqx;
        x_by       = dqy;
        state_next = cpc_pkg::ST_MEET_GETN;
      end
      cpc_pkg::ST_MEET_GETN: state_next = cpc_pkg::ST_MEET_GETD;
      cpc_pkg::ST_MEET_GETD: state_next = cpc_pkg::ST_MEET_MUL;
      cpc_pkg::ST_MEET_MUL: begin
        state_next = (den == '0) ? cpc_pkg::ST_MEET_PUSH : cpc_pkg::ST_MEET_SUM;
      end
      cpc_pkg::ST_MEET_SUM: state_next = cpc_pkg::ST_MEET_GO;
      cpc_pkg::ST_MEET_GO: begin
        div_start  = 1'b1;
        state_next = cpc_pkg::ST_MEET_DIV;
      end
      cpc_pkg::ST_MEET_DIV: begin
        if (div_done) begin
          state_next = axis ? cpc_pkg::ST_MEET_PUSH : cpc_pkg::ST_MEET_MUL;
        end
      end
      cpc_pkg::ST_MEET_PUSH: begin
        wr_data = {ry, rx};
        if (room_w) begin
          mem_we = 1'b1;
        end
        state_next = ret_close ? cpc_pkg::ST_PASS_FIN : cpc_pkg::ST_PASS_PUSH;
      end
      cpc_pkg::ST_OUT_RD: state_next = cpc_pkg::ST_OUT_LD;
      cpc_pkg::ST_OUT_LD: begin
        if (slot_free) begin
          state_next = (j + LW'(1) == len) ? cpc_pkg::ST_IDLE : cpc_pkg::ST_OUT_RD;
        end
      end
      cpc_pkg::ST_EMPTY: begin
        if (slot_free) begin
          state_next = cpc_pkg::ST_IDLE;
        end
      end
      default: state_next = cpc_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sel      <= 1'b0;
      cnt      <= '0;
      ovf_flag <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !m_load) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        cpc_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tlast) begin
              cnt      <= '0;
              ovf_flag <= 1'b0;
              ovf_run  <= ovf_flag || !room_s;
              len      <= LW'(cnt) + LW'(room_s);
              n        <= n_in;
              k        <= '0;
              cidx     <= '0;
              sgn_s    <= '0;
            end else if (room_s) begin
              cnt <= cnt + CW'(1);
            end else begin
              ovf_flag <= 1'b1;
            end
          end
        end
        cpc_pkg::ST_CV_RD: begin
          // slide the three-vertex window around the clip polygon
          a0x  <= a1x;
          a0y  <= a1y;
          a1x  <= a2x;
          a1y  <= a2y;
          a2x  <= cfg_x(cidx);
          a2y  <= cfg_y(cidx);
          cidx <= (cidx + 3'd1 == n) ? 3'd0 : cidx + 3'd1;
          k    <= k + 4'd1;
        end
        cpc_pkg::ST_CV_EVAL: begin
          sgn_s   <= s_new;
          ori_neg <= s_new.neg;
          e       <= '0;
        end
        cpc_pkg::ST_EDGE_Q1: begin
          q1x <= cfg_x(e);
          q1y <= cfg_y(e);
          e2  <= (e + 3'd1 == n) ? 3'd0 : e + 3'd1;
        end
        cpc_pkg::ST_EDGE_Q2: begin
          dqx  <= dif(cfg_x(e2), q1x);
          dqy  <= dif(cfg_y(e2), q1y);
          j    <= '0;
          wlen <= '0;
        end
        cpc_pkg::ST_PASS_VIS: begin
          cx <= rd_x;
          cy <= rd_y;
        end
        cpc_pkg::ST_PASS_DEC: begin
          vc <= vis_now;
          if (j != '0 && cpc_pkg::sign_opp(vs, vis_now)) begin
            m1x       <= sx;
            m1y       <= sy;
            m2x       <= cx;
            m2y       <= cy;
            ret_close <= 1'b0;
            axis      <= 1'b0;
          end
        end
        cpc_pkg::ST_PASS_PUSH: begin
          if (!vc.neg) begin
            if (room_w) begin
              wlen <= wlen + LW'(1);
            end else begin
              ovf_run <= 1'b1;
            end
          end
          sx <= cx;
          sy <= cy;
          vs <= vc;
          if (j == '0) begin
            fx <= cx;
            fy <= cy;
            vf <= vc;
          end
          j <= j + LW'(1);
        end
        cpc_pkg::ST_PASS_END: begin
          // closing edge from the last vertex back to the first
          m1x       <= sx;
          m1y       <= sy;
          m2x       <= fx;
          m2y       <= fy;
          ret_close <= 1'b1;
          axis      <= 1'b0;
        end
        cpc_pkg::ST_PASS_FIN: begin
          len <= wlen;
          sel <= ~sel;
          e   <= e + 3'd1;
          j   <= '0;
        end
        cpc_pkg::ST_MEET_GETN: num <= x_res;
        cpc_pkg::ST_MEET_GETD: den <= x_res;
        cpc_pkg::ST_MEET_MUL: begin
          if (den == '0) begin
            rx <= m1x;
            ry <= m1y;
          end else begin
            prod_a <= (axis ? m1y : m1x) * den;
            prod_b <= dp_sel * num;
          end
        end
        cpc_pkg::ST_MEET_SUM: numer <= NW'(prod_a) + NW'(prod_b);
        cpc_pkg::ST_MEET_DIV: begin
          if (div_done) begin
            if (axis) begin
              ry <= div_q;
            end else begin
              rx   <= div_q;
              axis <= 1'b1;
            end
          end
        end
        cpc_pkg::ST_MEET_PUSH: begin
          if (room_w) begin
            wlen <= wlen + LW'(1);
          end else begin
            ovf_run <= 1'b1;
          end
        end
        cpc_pkg::ST_OUT_LD: begin
          if (slot_free) begin
            m_valid <= 1'b1;
            ox      <= FW'(rd_x);
            oy      <= FW'(rd_y);
            olast   <= (j + LW'(1) == len);
            oempty  <= 1'b0;
            oovf    <= ovf_run;
            j       <= j + LW'(1);
          end
        end
        cpc_pkg::ST_EMPTY: begin
          if (slot_free) begin
            m_valid <= 1'b1;
            ox      <= '0;
            oy      <= '0;
            olast   <= 1'b1;
            oempty  <= 1'b1;
            oovf    <= ovf_run;
          end
        end
        default: ;
      endcase
    end
  end

  // reads always come from the current bank and pass writes go to the other one,
  // so during a pass a read and a write never meet on one entry
  cpc_mem #(
    .DEPTH (CAP),
    .DW    (PW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_bank (sel),
    .rd_addr (j[AW-1:0]),
    .rd_data (rd_data)
  );

  cpc_cross #(
    .XW (XW)
  ) u_cross (
    .clk (clk),
    .ax  (x_ax),
    .ay  (x_ay),
    .bx  (x_bx),
    .by  (x_by),
    .res (x_res)
  );

  cpc_div #(
    .NW (NW),
    .DW (RW),
    .QW (XW),
    .OW (CB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign s_axis_tready = (state == cpc_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {oy, ox};
  assign m_axis_tlast  = olast;
  assign m_axis_tuser  = {oovf, oempty};

  // stores stay inside the store depth
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (wr_addr < AW'(CAP)))
    else $error("vertex store write beyond depth");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    (state == cpc_pkg::ST_PASS_FIN) |=> (len <= LW'(CAP)))
    else $error("polygon length beyond store depth");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("empty result not marked last or not zero");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == cpc_pkg::ST_MEET_DIV))
    else $error("divider started outside the intersection sequence");

endmodule

>>> tb/convex_polygon_clipper_tb.sv
// testbench for convex_polygon_clipper: directed and random subject polygons against
// changing clip polygons, checked item by item against a built-in clipping predictor
// depends on cpc_pkg and the rtl under hdl

module convex_polygon_clipper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUBJ_CAP    = cpc_pkg::MAX_SUBJECT_VERTS_DEF;
  localparam int CLIPV_CAP   = cpc_pkg::MAX_CLIP_VERTS_DEF;
  localparam int PASS_CAP    = SUBJ_CAP + CLIPV_CAP;
  localparam int ITEM_TARGET = 380;
  localparam int STALL_LIMIT = 60000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } vertex_item_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic        empty;
    logic        ovf;
  } clipped_item_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // vertex_x, vertex_y
  logic        s_axis_tlast;   // final_vertex
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // out_x, out_y
  logic        m_axis_tlast;   // out_last
  logic [1:0]  m_axis_tuser;   // out_empty, input_overflow
  logic        cfg_we;
  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_data;

  convex_polygon_clipper i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pending subject vertices and clipped vertices still owed by the block
  vertex_item_t  pending_vertices[$];
  clipped_item_t clipped_q[$];

  int  mismatches;
  int  items_queued;
  bit  idle_on;       // random gaps on both sides
  int  hold_id;       // bumped to ask the receiver for a long hold-off
  int  hold_seen;

  // shadow of the clip registers
  logic        clip_en;
  logic [2:0]  clip_cnt;
  logic [31:0] clip_vert[CLIPV_CAP];

  // predictor state
  point_t subj_pts[PASS_CAP];
  point_t work_pts[PASS_CAP];
  int     subj_len;
  bit     subj_ovf;
  int     orient;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic point_t clip_point(int i);
    point_t p;
    p.x = longint'($signed(clip_vert[i][15:0]));
    p.y = longint'($signed(clip_vert[i][31:16]));
    return p;
  endfunction

  // which side of the clip edge q1->q2 a point lies on, relative to the orientation
  function automatic int side_of(point_t p, point_t q1, point_t q2);
    return sgn(cross2(q1.x - p.x, q1.y - p.y, q2.x - q1.x, q2.y - q1.y)) * orient;
  endfunction

  // crossing of segment p1->p2 with the clip edge line, truncated toward zero
  function automatic point_t crossing(point_t p1, point_t p2, point_t q1, point_t q2);
    longint dpx, dpy, dqx, dqy, num, den;
    point_t r;
    dpx = p2.x - p1.x;
    dpy = p2.y - p1.y;
    dqx = q2.x - q1.x;
    dqy = q2.y - q1.y;
    num = cross2(q1.x - p1.x, q1.y - p1.y, dqx, dqy);
    den = cross2(dpx, dpy, dqx, dqy);
    if (den == 0) return p1;
    r.x = (p1.x * den + dpx * num) / den;
    r.y = (p1.y * den + dpy * num) / den;
    return r;
  endfunction

  function automatic void work_push(ref int len, input point_t p, ref bit ovf);
    if (len < PASS_CAP) begin
      work_pts[len] = p;
      len++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  // one pass against edge q1->q2, result copied back into subj_pts unless it is empty
  function automatic int clip_edge(int n, point_t q1, point_t q2, ref bit ovf);
    int len;
    point_t s, f, c;
    len = 0;
    s = subj_pts[0];
    f = subj_pts[0];
    for (int j = 0; j < n; j++) begin
      c = subj_pts[j];
      if (j > 0 && side_of(s, q1, q2) * side_of(c, q1, q2) < 0)
        work_push(len, crossing(s, c, q1, q2), ovf);
      s = c;
      if (side_of(s, q1, q2) >= 0) work_push(len, s, ovf);
    end
    if (len == 0) return 0;
    if (side_of(s, q1, q2) * side_of(f, q1, q2) < 0)
      work_push(len, crossing(s, f, q1, q2), ovf);
    for (int j = 0; j < len; j++) subj_pts[j] = work_pts[j];
    return len;
  endfunction

  // all nonzero turns must agree; their sign sets the orientation
  function automatic bit clip_is_convex(int n);
    int s, z;
    point_t a0, a1, a2;
    s = 0;
    for (int i = 0; i < n; i++) begin
      a0 = clip_point(i);
      a1 = clip_point((i + 1) % n);
      a2 = clip_point((i + 2) % n);
      z = sgn(cross2(a1.x - a0.x, a1.y - a0.y, a2.x - a1.x, a2.y - a1.y));
      if (s == 0) s = z;
      if (z != 0 && z != s) begin
        orient = 0;
        return 1'b0;
      end
    end
    orient = s;
    return s != 0;
  endfunction

  // takes one accepted subject vertex, queues the clipped vertices it causes
  function automatic void predict_clip(vertex_item_t v);
    int n, len;
    bit ok, ovf;
    clipped_item_t r;
    if (subj_len < SUBJ_CAP) begin
      subj_pts[subj_len].x = longint'($signed(v.x));
      subj_pts[subj_len].y = longint'($signed(v.y));
      subj_len++;
    end else begin
      subj_ovf = 1'b1;
    end
    if (!v.last) return;
    ovf = subj_ovf;
    len = subj_len;
    n = (clip_cnt > CLIPV_CAP) ? CLIPV_CAP : int'(clip_cnt);
    ok = (n > 0) && clip_is_convex(n) && clip_en;
    if (n == 0) orient = 0;
    if (ok)
      for (int i = 0; i < n && len > 0; i++)
        len = clip_edge(len, clip_point(i), clip_point((i + 1) % n), ovf);
    subj_len = 0;
    subj_ovf = 1'b0;
    if (!ok || len == 0) begin
      r = '{x: 16'h0, y: 16'h0, last: 1'b1, empty: 1'b1, ovf: ovf};
      clipped_q.push_back(r);
      return;
    end
    for (int i = 0; i < len; i++) begin
      r.x = subj_pts[i].x[15:0];
      r.y = subj_pts[i].y[15:0];
      r.last = (i == len - 1);
      r.empty = 1'b0;
      r.ovf = ovf;
      clipped_q.push_back(r);
    end
  endfunction

  // sender side: one item in flight, random gaps between items while idle_on is set
  vertex_item_t cur_vertex;
  int           send_gap;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_clip(cur_vertex);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          cur_vertex = pending_vertices.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_vertex.y, cur_vertex.x};
          s_axis_tlast <= cur_vertex.last;
          if (idle_on) send_gap = rand_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  int recv_gap;
  int hold_cnt;
  clipped_item_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
      hold_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (clipped_q.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[15:0], 16'h0);
        end else begin
          want = clipped_q.pop_front();
          if (m_axis_tdata[15:0] !== want.x) report_mismatch("out_x", m_axis_tdata[15:0], want.x);
          if (m_axis_tdata[31:16] !== want.y)
            report_mismatch("out_y", m_axis_tdata[31:16], want.y);
          if (m_axis_tlast !== want.last)
            report_mismatch("out_last", {15'b0, m_axis_tlast}, {15'b0, want.last});
          if (m_axis_tuser[0] !== want.empty)
            report_mismatch("out_empty", {15'b0, m_axis_tuser[0]}, {15'b0, want.empty});
          if (m_axis_tuser[1] !== want.ovf)
            report_mismatch("input_overflow", {15'b0, m_axis_tuser[1]}, {15'b0, want.ovf});
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (hold_id != hold_seen) begin
        hold_seen = hold_id;
        hold_cnt = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on) recv_gap = rand_gap();
      end
    end
  end

  // watchdog: cycles with no handshake of any kind
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(cpc_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      cpc_pkg::REG_CLIP_ENABLED: begin
        clip_en = value[0];
      end
      cpc_pkg::REG_CLIP_COUNT: begin
        clip_cnt = value[2:0];
      end
      default: begin
        clip_vert[int'(idx) - int'(cpc_pkg::REG_CLIP_VERTEX_0)] = value;
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pack_xy(int x, int y);
    return {y[15:0], x[15:0]};
  endfunction

  task automatic write_clip(bit en, int cnt, logic [31:0] v[CLIPV_CAP]);
    reg_write(cpc_pkg::REG_CLIP_ENABLED, {31'b0, en});
    reg_write(cpc_pkg::REG_CLIP_COUNT, 32'(cnt));
    for (int i = 0; i < CLIPV_CAP; i++)
      reg_write(cpc_pkg::reg_idx_t'(int'(cpc_pkg::REG_CLIP_VERTEX_0) + i), v[i]);
  endtask

  function automatic void queue_vertex(int x, int y, bit last);
    vertex_item_t v;
    v.x = x[15:0];
    v.y = y[15:0];
    v.last = last;
    pending_vertices.push_back(v);
    items_queued++;
  endfunction

  // block is idle once everything is sent and every clipped vertex has come back
  task automatic wait_idle();
    while (pending_vertices.size() > 0 || s_axis_tvalid || clipped_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random clip setting: mostly convex hexagon subsets, plus odd and empty-result cases
  int cx, cy, rad;

  task automatic random_clip();
    logic [31:0] v[CLIPV_CAP];
    int hx[6], hy[6];
    int kind, cnt;
    bit en, rev;
    kind = $urandom_range(0, 19);
    cx = $urandom_range(0, 4000) - 2000;
    cy = $urandom_range(0, 4000) - 2000;
    rad = (kind == 19) ? 32767 : $urandom_range(20, 3000);
    hx = '{rad, rad / 2, -rad / 2, -rad, -rad / 2, rad / 2};
    hy = '{0, rad, rad, 0, -rad, -rad};
    cnt = $urandom_range(3, 6);
    rev = $urandom_range(0, 1);
    en = 1'b1;
    for (int i = 0; i < CLIPV_CAP; i++) begin
      int k;
      k = rev ? (cnt - 1 - i) : i;
      v[i] = (i < cnt) ? pack_xy(cx + hx[k], cy + hy[k]) : $urandom;
    end
    case (kind)
      0: begin
        for (int i = 0; i < CLIPV_CAP; i++) v[i] = $urandom;
      end
      1: begin
        en = 1'b0;
      end
      2: begin
        cnt = 0;
      end
      3: begin
        cnt = 7;
        for (int i = 0; i < CLIPV_CAP; i++) v[i] = pack_xy(cx + hx[i], cy + hy[i]);
      end
      4: begin
        // collinear clip vertices give no usable area
        for (int i = 0; i < CLIPV_CAP; i++) v[i] = pack_xy(cx + 10 * i, cy + 7 * i);
      end
      default: begin
      end
    endcase
    write_clip(en, cnt, v);
  endtask

  task automatic random_polygon();
    int kind, n;
    kind = $urandom_range(0, 9);
    n = (kind == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if (kind == 1)
        queue_vertex($urandom_range(0, 65535), $urandom_range(0, 65535), i == n - 1);
      else
        queue_vertex(cx + $urandom_range(0, 4 * rad) - 2 * rad,
                     cy + $urandom_range(0, 4 * rad) - 2 * rad, i == n - 1);
    end
  endtask

  initial begin
    logic [31:0] sq[CLIPV_CAP];
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    items_queued = 0;
    idle_on = 1'b0;
    hold_id = 0;
    hold_seen = 0;
    clip_en = 1'b0;
    clip_cnt = '0;
    for (int i = 0; i < CLIPV_CAP; i++) clip_vert[i] = '0;
    subj_len = 0;
    subj_ovf = 1'b0;
    orient = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // clipping disabled after reset: empty result
    queue_vertex(0, 0, 0);
    queue_vertex(10, 0, 0);
    queue_vertex(0, 10, 1);
    wait_idle();

    // square window, counter-clockwise
    sq = '{pack_xy(-1000, -1000), pack_xy(1000, -1000), pack_xy(1000, 1000),
           pack_xy(-1000, 1000), 32'h0, 32'h0};
    write_clip(1'b1, 4, sq);
    // fully inside
    queue_vertex(-10, -10, 0);
    queue_vertex(10, -10, 0);
    queue_vertex(10, 10, 1);
    // single vertex inside, then one outside (clipped away)
    queue_vertex(5, 5, 1);
    queue_vertex(5000, 5000, 1);
    // coordinate extremes, clipped down to the window
    queue_vertex(-32768, -32768, 0);
    queue_vertex(32767, -32768, 0);
    queue_vertex(32767, 32767, 0);
    queue_vertex(-32768, 32767, 1);
    // straddling triangle, intersections on the right and top edges
    queue_vertex(0, 0, 0);
    queue_vertex(3000, 500, 0);
    queue_vertex(-200, 2500, 1);
    // fully outside
    queue_vertex(2000, 2000, 0);
    queue_vertex(3000, 2000, 0);
    queue_vertex(2500, 3000, 1);
    wait_idle();

    // random phases, each with a fresh clip setting
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      random_clip();
      idle_on = (phase % 4) != 3;
      if (phase == 2) hold_id++;  // receiver holds off while the sender keeps offering
      for (int p = 0; p < 5; p++) random_polygon();
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
